[src/ascd_pkg.sv]
`default_nettype none

package ascd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned TPS_W  = 6;
  localparam int unsigned STEPS_W = 9;
  localparam int unsigned POS_W  = 32;

  localparam logic [TPS_W-1:0] TPS_RESET = 6'd10;

  localparam logic [BYTE_W-1:0] SIGN_MINUS = 8'd45;
  localparam logic [BYTE_W-1:0] DIGIT_ZERO = 8'd48;
  localparam logic [6:0]        DEC_BASE   = 7'd10;
  localparam logic [STEPS_W-1:0] STEP_MULT = 9'd4;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_DROP   = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  localparam logic [3:0] COIL_P0 = 4'b0101;
  localparam logic [3:0] COIL_P1 = 4'b0110;
  localparam logic [3:0] COIL_P2 = 4'b1010;
  localparam logic [3:0] COIL_P3 = 4'b1001;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [POS_W-1:0] position;
    logic                    busy_res;
    logic                    stepped;
    logic [3:0]              coils;
  } res_t;

  function automatic logic is_digit(input logic [BYTE_W-1:0] b);
    return (b >= DIGIT_ZERO) && (b <= DIGIT_ZERO + 8'd9);
  endfunction

  function automatic logic [3:0] coil_pattern(input logic [1:0] ph);
    logic [3:0] p;
    unique case (ph)
      2'd0:    p = COIL_P0;
      2'd1:    p = COIL_P1;
      2'd2:    p = COIL_P2;
      default: p = COIL_P3;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

[src/ascii_stepper_command_driver.sv]
`default_nettype none

// Full-step stepper sequencer fed by a word stream of received bytes and timer
// ticks (in_tuser = 1 for a tick). Three bytes make a command: a sign byte ('-'
// reverses) and two ASCII digits; the move is 4x that value in steps, added to
// the signed position when the command is taken. Bytes arriving while a move
// runs are dropped with status 1; a non-digit command is rejected with status 2.
// Every ticks_per_step ticks one step is driven onto the coils. Each input word
// yields exactly one result word, held in the output register or, while the
// output stalls, in the skid entry. One word per cycle is sustained while the
// output does not stall, and a two-entry output buffer keeps the input open
// while a result waits.
module ascii_stepper_command_driver (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [5:0]  cfg_wdata,   // ticks_per_step
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [7:0]  in_tdata,    // rx_byte
  input  wire logic        in_tuser,    // cmd: 0 byte, 1 tick
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [39:0] out_tdata    // status[1:0] position[31:0] busy_res stepped coils[3:0]
);

  logic [ascd_pkg::TPS_W-1:0]   tps_r;
  logic [ascd_pkg::BYTE_W-1:0]  buf0_r, buf0_nxt, buf1_r, buf1_nxt;
  logic [1:0]                   cnt_r, cnt_nxt;
  logic [ascd_pkg::STEPS_W-1:0] steps_r, steps_nxt;
  logic [1:0]                   phase_r, phase_nxt;
  logic                         rev_r, rev_nxt;
  logic [ascd_pkg::TPS_W-1:0]   tick_r, tick_nxt, tick_inc;
  logic signed [ascd_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [3:0]                   coil_r, coil_nxt;

  logic                         accept;
  logic                         stepped;
  logic [1:0]                   status;
  logic [3:0]                   tens, units;
  logic [6:0]                   value;
  logic [ascd_pkg::STEPS_W-1:0] n_steps;
  ascd_pkg::res_t               res;

  ascd_pkg::res_t out_r, skid_r;
  logic           out_valid_r, skid_valid_r;

  assign in_tready = !skid_valid_r;
  assign accept    = in_tvalid && in_tready;

  assign tens     = 4'(buf1_r - ascd_pkg::DIGIT_ZERO);
  assign units    = 4'(in_tdata - ascd_pkg::DIGIT_ZERO);
  assign value    = 7'(tens) * ascd_pkg::DEC_BASE + 7'(units);
  assign n_steps  = 9'(value) * ascd_pkg::STEP_MULT;
  assign tick_inc = tick_r + 6'd1;

  always_comb begin
    buf0_nxt  = buf0_r;
    buf1_nxt  = buf1_r;
    cnt_nxt   = cnt_r;
    steps_nxt = steps_r;
    phase_nxt = phase_r;
    rev_nxt   = rev_r;
    tick_nxt  = tick_r;
    pos_nxt   = pos_r;
    coil_nxt  = coil_r;
    stepped   = 1'b0;
    status    = ascd_pkg::ST_OK;
    if (accept) begin
      if (in_tuser == ascd_pkg::KIND_BYTE) begin
        if (steps_r != '0) begin
          status = ascd_pkg::ST_DROP;
        end else begin
          case (cnt_r)
            2'd0: begin
              buf0_nxt = in_tdata;
              cnt_nxt  = 2'd1;
            end
            2'd1: begin
              buf1_nxt = in_tdata;
              cnt_nxt  = 2'd2;
            end
            default: begin
              cnt_nxt = 2'd0;
              if (!ascd_pkg::is_digit(buf1_r) || !ascd_pkg::is_digit(in_tdata)) begin
                status = ascd_pkg::ST_REJECT;
              end else begin
                rev_nxt   = (buf0_r == ascd_pkg::SIGN_MINUS);
                steps_nxt = n_steps;
                tick_nxt  = '0;
                if (buf0_r == ascd_pkg::SIGN_MINUS) begin
                  pos_nxt = pos_r - 32'(n_steps);
                end else begin
                  pos_nxt = pos_r + 32'(n_steps);
                end
              end
            end
          endcase
        end
      end else begin
        if (steps_r != '0) begin
          tick_nxt = tick_inc;
          if (tick_inc >= tps_r) begin
            tick_nxt  = '0;
            coil_nxt  = ascd_pkg::coil_pattern(phase_r);
            phase_nxt = rev_r ? phase_r - 2'd1 : phase_r + 2'd1;
            steps_nxt = steps_r - 9'd1;
            stepped   = 1'b1;
          end
        end else begin
          tick_nxt = '0;
        end
      end
    end
    res.status   = status;
    res.position = pos_nxt;
    res.busy_res = (steps_nxt != '0);
    res.stepped  = stepped;
    res.coils    = coil_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r   <= ascd_pkg::TPS_RESET;
      cnt_r   <= '0;
      steps_r <= '0;
      phase_r <= '0;
      rev_r   <= 1'b0;
      tick_r  <= '0;
      pos_r   <= '0;
      coil_r  <= '0;
    end else begin
      if (cfg_we) begin
        tps_r <= cfg_wdata;
      end
      cnt_r   <= cnt_nxt;
      steps_r <= steps_nxt;
      phase_r <= phase_nxt;
      rev_r   <= rev_nxt;
      tick_r  <= tick_nxt;
      pos_r   <= pos_nxt;
      coil_r  <= coil_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf0_r <= buf0_nxt;
    buf1_r <= buf1_nxt;
  end

  // output register plus skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= accept;
      end
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (accept) begin
        out_r <= res;
      end
    end else if (accept) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

endmodule

`default_nettype wire

[src/ascd_checker.sv]
`default_nettype none

module ascd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata
);

  logic [3:0] coils;
  logic       stepped;
  logic [1:0] status;

  assign coils   = out_tdata[3:0];
  assign stepped = out_tdata[4];
  assign status  = out_tdata[39:38];

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // every accepted word is followed by out_tvalid on the next cycle
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted word produced no result");

  a_coils: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (coils == 4'b0000 || coils == 4'b0101 || coils == 4'b0110 ||
                    coils == 4'b1010 || coils == 4'b1001))
    else $error("illegal coil pattern");

  a_step_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && stepped |-> status == 2'd0 && coils != 4'b0000)
    else $error("step flagged with error status or idle coils");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> status != 2'd3)
    else $error("undefined status code");

endmodule

bind ascii_stepper_command_driver ascd_checker u_ascd_checker (.*);

`default_nettype wire
